// ----- rtl/kts_pkg.sv -----
// Shared constants for the keyframe track sampler.
package kts_pkg;

  localparam int unsigned MAX_KEYS_DEF = 64;

  // tuser codes on the input stream
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_TRACK_MODE = 2'd0;
  localparam logic [1:0] REG_KEY_COUNT  = 2'd1;

  localparam logic MODE_VECTOR = 1'b0;
  localparam logic MODE_QUAT   = 1'b1;

endpackage

// ----- rtl/kts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module kts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/keyframe_track_sampler_unit.sv -----
// Keyframe track sampler: key store, segment search, factor divide, lerp / quaternion nlerp.
// A load writes the key memories directly. A sample runs the segment search, then the factor
// divide when needed; quaternion mode adds 3 normalizations (a square root and 4 divides
// each); the divides and roots run on the shared bit-serial divider and root stepper.
// One item at a time; the result sits in an output register while the next item starts.
// Reset (rst_ni low, async) sets track_mode 0, key_count 1 and empties the output; key
// memories are not cleared.
module keyframe_track_sampler_unit #(
  parameter int unsigned MAX_KEYS = kts_pkg::MAX_KEYS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // key_index[5:0], key_time[37:6], comp_x[69:38], comp_y[101:70], comp_z[133:102],
  // comp_w[165:134], sample_time[197:166], zero pad
  input  logic [199:0] s_axis_tdata,
  // operation
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
  output logic [127:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [7:0]   cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_KEYS);
  localparam int unsigned KW = $clog2(MAX_KEYS + 1);
  localparam logic [5:0] DIV_LAST  = 6'd47;
  localparam logic [5:0] SQRT_LAST = 6'd31;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ONEW  = 5'd2;
  localparam logic [4:0] S_ONEC  = 5'd3;
  localparam logic [4:0] S_SRCH  = 5'd4;
  localparam logic [4:0] S_SRW   = 5'd5;
  localparam logic [4:0] S_SRC   = 5'd6;
  localparam logic [4:0] S_RD0W  = 5'd7;
  localparam logic [4:0] S_RD0C  = 5'd8;
  localparam logic [4:0] S_RD1W  = 5'd9;
  localparam logic [4:0] S_RD1C  = 5'd10;
  localparam logic [4:0] S_FDIV  = 5'd11;
  localparam logic [4:0] S_FWR   = 5'd12;
  localparam logic [4:0] S_NMUL  = 5'd13;
  localparam logic [4:0] S_NACC  = 5'd14;
  localparam logic [4:0] S_NSQ   = 5'd15;
  localparam logic [4:0] S_NDST  = 5'd16;
  localparam logic [4:0] S_NDIV  = 5'd17;
  localparam logic [4:0] S_NDWR  = 5'd18;
  localparam logic [4:0] S_DMUL  = 5'd19;
  localparam logic [4:0] S_DACC  = 5'd20;
  localparam logic [4:0] S_DNEG  = 5'd21;
  localparam logic [4:0] S_LMUL  = 5'd22;
  localparam logic [4:0] S_LACC  = 5'd23;
  localparam logic [4:0] S_OUT   = 5'd24;

  localparam logic [1:0] PH_NA = 2'd0;
  localparam logic [1:0] PH_NB = 2'd1;
  localparam logic [1:0] PH_NR = 2'd2;

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    logic [31:0] r;
    if (v > 35'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -35'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // control state
  logic [4:0]    state_q, state_d;
  logic          mode_q, mode_d;
  logic [6:0]    kcnt_q, kcnt_d;
  logic          out_valid_q, out_valid_d;
  // datapath
  logic [KW-1:0] n_q, n_d, i_q, i_d;
  logic [31:0]   t_q, t_d, t0_q, t0_d;
  logic [AW-1:0] seg_q, seg_d, addr_q, addr_d;
  logic [16:0]   f_q, f_d;
  logic [1:0]    k_q, k_d, ph_q, ph_d;
  logic [5:0]    cnt_q, cnt_d;
  logic [63:0]   s_q, s_d, sq_s_q, sq_s_d, sq_r_q, sq_r_d, sq_bit_q, sq_bit_d;
  logic [31:0]   div_rem_q, div_rem_d, div_dvs_q, div_dvs_d;
  logic [47:0]   div_quo_q, div_quo_d;
  logic signed [67:0] dot_q, dot_d, prod_q, prod_d;
  logic signed [31:0] qa_q [4];
  logic signed [31:0] qa_d [4];
  logic signed [31:0] qb_q [4];
  logic signed [31:0] qb_d [4];
  logic [127:0]  out_data_q, out_data_d;

  // memories
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   time_rd;
  logic [127:0]  comp_rd, comp_wr;
  logic [31:0]   ki32;

  assign ki32      = {26'd0, s_axis_tdata[5:0]};
  assign ram_waddr = ki32[AW-1:0];
  assign ram_we    = s_axis_tvalid && s_axis_tready && (s_axis_tuser == kts_pkg::OP_LOAD)
                     && (ki32 < 32'(MAX_KEYS));
  assign comp_wr   = s_axis_tdata[165:38];

  kts_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_time_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(s_axis_tdata[37:6]),
    .raddr_i(addr_q),
    .rdata_o(time_rd)
  );

  kts_ram #(.WIDTH(128), .DEPTH(MAX_KEYS)) u_comp_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(comp_wr),
    .raddr_i(addr_q),
    .rdata_o(comp_rd)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

  // shared units
  logic signed [33:0] mul_a, mul_b;
  logic [32:0]   div_sh;
  logic          div_ge;
  logic [31:0]   div_rem_n;
  logic [47:0]   div_quo_n;
  logic [63:0]   sq_rb, sq_r_n, sq_s_n;
  logic signed [31:0] nv;
  logic [31:0]   nv_abs;
  logic [KW-1:0] ip1;
  logic [31:0]   kc32, n32;
  logic signed [32:0] num, den;
  logic signed [32:0] lrp_d;
  logic signed [34:0] lrp_sum;
  logic [31:0]   nwr;
  logic [47:0]   mag;

  always_comb begin
    nv     = (ph_q == PH_NB) ? qb_q[k_q] : qa_q[k_q];
    nv_abs = nv[31] ? (~nv + 32'd1) : nv;
    lrp_d  = 33'(qb_q[k_q]) - 33'(qa_q[k_q]);
    mul_a  = 34'(nv);
    mul_b  = 34'(nv);
    if (state_q == S_DMUL) begin
      mul_a = 34'(qa_q[k_q]);
      mul_b = 34'(qb_q[k_q]);
    end else if (state_q == S_LMUL) begin
      mul_a = 34'(lrp_d);
      mul_b = $signed({17'd0, f_q});
    end
    div_sh    = {div_rem_q, div_quo_q[47]};
    div_ge    = div_sh >= {1'b0, div_dvs_q};
    div_rem_n = div_ge ? 32'(div_sh - {1'b0, div_dvs_q}) : div_sh[31:0];
    div_quo_n = {div_quo_q[46:0], div_ge};
    sq_rb     = sq_r_q + sq_bit_q;
    if (sq_s_q >= sq_rb) begin
      sq_s_n = sq_s_q - sq_rb;
      sq_r_n = (sq_r_q >> 1) + sq_bit_q;
    end else begin
      sq_s_n = sq_s_q;
      sq_r_n = sq_r_q >> 1;
    end
    ip1  = i_q + 1'b1;
    kc32 = {25'd0, kcnt_q};
    if (kc32 == 32'd0) n32 = 32'd1;
    else if (kc32 > 32'(MAX_KEYS)) n32 = 32'(MAX_KEYS);
    else n32 = kc32;
    num     = $signed({1'b0, t_q}) - $signed({1'b0, t0_q});
    den     = $signed({1'b0, time_rd}) - $signed({1'b0, t0_q});
    // floor of the product over 2^16 is its arithmetic shift
    lrp_sum = 35'(qa_q[k_q]) + 35'($signed(prod_q[49:16]));
    mag     = div_quo_q;
    if (nv[31]) nwr = (mag > 48'h8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    else nwr = (mag > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  end

  always_comb begin
    state_d = state_q;   mode_d = mode_q;   kcnt_d = kcnt_q;
    out_valid_d = out_valid_q;  out_data_d = out_data_q;
    n_d = n_q;  i_d = i_q;  t_d = t_q;  t0_d = t0_q;  seg_d = seg_q;  addr_d = addr_q;
    f_d = f_q;  k_d = k_q;  ph_d = ph_q;  cnt_d = cnt_q;  s_d = s_q;
    sq_s_d = sq_s_q;  sq_r_d = sq_r_q;  sq_bit_d = sq_bit_q;
    div_rem_d = div_rem_q;  div_quo_d = div_quo_q;  div_dvs_d = div_dvs_q;
    dot_d = dot_q;  prod_d = prod_q;
    qa_d = qa_q;  qb_d = qb_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        kts_pkg::REG_TRACK_MODE: mode_d = cfg_data_i[0];
        kts_pkg::REG_KEY_COUNT:  kcnt_d = cfg_data_i[6:0];
        default: ;
      endcase
    end
    if (m_axis_tvalid && m_axis_tready) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tuser == kts_pkg::OP_SAMPLE) begin
          t_d = s_axis_tdata[197:166];
          n_d = n32[KW-1:0];
          i_d = '0;
          if (n32 == 32'd1) begin
            addr_d  = '0;
            state_d = S_ONEW;
          end else begin
            state_d = S_SRCH;
          end
        end
      end
      S_ONEW: state_d = S_ONEC;
      S_ONEC: begin
        qa_d[0] = comp_rd[31:0];
        qa_d[1] = comp_rd[63:32];
        qa_d[2] = comp_rd[95:64];
        qa_d[3] = (mode_q == kts_pkg::MODE_VECTOR) ? 32'sd0 : comp_rd[127:96];
        state_d = S_OUT;
      end
      S_SRCH: begin
        if (ip1 >= n_q) begin
          seg_d = '0;  addr_d = '0;  state_d = S_RD0W;
        end else begin
          addr_d = ip1[AW-1:0];  state_d = S_SRW;
        end
      end
      S_SRW: state_d = S_SRC;
      S_SRC: begin
        if (t_q < time_rd) begin
          seg_d = i_q[AW-1:0];  addr_d = i_q[AW-1:0];  state_d = S_RD0W;
        end else begin
          i_d = ip1;  state_d = S_SRCH;
        end
      end
      S_RD0W: state_d = S_RD0C;
      S_RD0C: begin
        t0_d    = time_rd;
        qa_d[0] = comp_rd[31:0];   qa_d[1] = comp_rd[63:32];
        qa_d[2] = comp_rd[95:64];  qa_d[3] = comp_rd[127:96];
        addr_d  = seg_q + 1'b1;
        state_d = S_RD1W;
      end
      S_RD1W: state_d = S_RD1C;
      S_RD1C: begin
        qb_d[0] = comp_rd[31:0];   qb_d[1] = comp_rd[63:32];
        qb_d[2] = comp_rd[95:64];  qb_d[3] = comp_rd[127:96];
        k_d = '0;  ph_d = PH_NA;  s_d = '0;
        if (den <= 33'sd0 || num <= 33'sd0) begin
          f_d = '0;
          state_d = (mode_q == kts_pkg::MODE_VECTOR) ? S_LMUL : S_NMUL;
        end else if (num >= den) begin
          f_d = 17'h10000;
          state_d = (mode_q == kts_pkg::MODE_VECTOR) ? S_LMUL : S_NMUL;
        end else begin
          div_rem_d = '0;
          div_quo_d = {num[31:0], 16'd0};
          div_dvs_d = den[31:0];
          cnt_d     = '0;
          state_d   = S_FDIV;
        end
      end
      S_FDIV: begin
        div_rem_d = div_rem_n;  div_quo_d = div_quo_n;  cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) state_d = S_FWR;
      end
      S_FWR: begin
        f_d = div_quo_q[16:0];
        state_d = (mode_q == kts_pkg::MODE_VECTOR) ? S_LMUL : S_NMUL;
      end
      // normalization of qa (or qb in phase NB)
      S_NMUL: begin
        prod_d = mul_a * mul_b;  state_d = S_NACC;
      end
      S_NACC: begin
        s_d = s_q + {2'd0, prod_q[63:2]};
        k_d = k_q + 1'b1;
        if (k_q == 2'd3) begin
          sq_s_d = s_q + {2'd0, prod_q[63:2]};
          sq_r_d = '0;  sq_bit_d = 64'h4000_0000_0000_0000;  cnt_d = '0;
          state_d = S_NSQ;
        end else begin
          state_d = S_NMUL;
        end
      end
      S_NSQ: begin
        sq_s_d = sq_s_n;  sq_r_d = sq_r_n;  sq_bit_d = sq_bit_q >> 2;  cnt_d = cnt_q + 1'b1;
        if (cnt_q == SQRT_LAST) begin
          k_d = '0;
          if (sq_r_n == 64'd0) begin
            // zero length: leave the vector as it is
            case (ph_q)
              PH_NA:   begin ph_d = PH_NB;  s_d = '0;  state_d = S_NMUL; end
              PH_NB:   begin dot_d = '0;  state_d = S_DMUL; end
              default: state_d = S_OUT;
            endcase
          end else begin
            state_d = S_NDST;
          end
        end
      end
      S_NDST: begin
        div_rem_d = '0;
        div_quo_d = {1'b0, nv_abs, 15'd0};
        div_dvs_d = sq_r_q[31:0];
        cnt_d     = '0;
        state_d   = S_NDIV;
      end
      S_NDIV: begin
        div_rem_d = div_rem_n;  div_quo_d = div_quo_n;  cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) state_d = S_NDWR;
      end
      S_NDWR: begin
        if (ph_q == PH_NB) qb_d[k_q] = nwr;
        else qa_d[k_q] = nwr;
        k_d = k_q + 1'b1;
        if (k_q == 2'd3) begin
          case (ph_q)
            PH_NA:   begin ph_d = PH_NB;  s_d = '0;  state_d = S_NMUL; end
            PH_NB:   begin dot_d = '0;  state_d = S_DMUL; end
            default: state_d = S_OUT;
          endcase
        end else begin
          state_d = S_NDST;
        end
      end
      S_DMUL: begin
        prod_d = mul_a * mul_b;  state_d = S_DACC;
      end
      S_DACC: begin
        dot_d = dot_q + prod_q;
        k_d = k_q + 1'b1;
        state_d = (k_q == 2'd3) ? S_DNEG : S_DMUL;
      end
      S_DNEG: begin
        if (dot_q < 68'sd0) begin
          for (int j = 0; j < 4; j++) qb_d[j] = sat32(-35'(qb_q[j]));
        end
        k_d = '0;
        state_d = S_LMUL;
      end
      S_LMUL: begin
        prod_d = mul_a * mul_b;  state_d = S_LACC;
      end
      S_LACC: begin
        qa_d[k_q] = sat32(lrp_sum);
        k_d = k_q + 1'b1;
        if (mode_q == kts_pkg::MODE_VECTOR && k_q == 2'd2) begin
          qa_d[3] = 32'sd0;
          state_d = S_OUT;
        end else if (k_q == 2'd3) begin
          k_d = '0;  ph_d = PH_NR;  s_d = '0;  state_d = S_NMUL;
        end else begin
          state_d = S_LMUL;
        end
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_d  = {qa_q[3], qa_q[2], qa_q[1], qa_q[0]};
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= kts_pkg::MODE_VECTOR;
      kcnt_q      <= 7'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      kcnt_q      <= kcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    n_q <= n_d;  i_q <= i_d;  t_q <= t_d;  t0_q <= t0_d;  seg_q <= seg_d;  addr_q <= addr_d;
    f_q <= f_d;  k_q <= k_d;  ph_q <= ph_d;  cnt_q <= cnt_d;  s_q <= s_d;
    sq_s_q <= sq_s_d;  sq_r_q <= sq_r_d;  sq_bit_q <= sq_bit_d;
    div_rem_q <= div_rem_d;  div_quo_q <= div_quo_d;  div_dvs_q <= div_dvs_d;
    dot_q <= dot_d;  prod_q <= prod_d;
    qa_q <= qa_d;  qb_q <= qb_d;
  end

endmodule

// ----- tb/keyframe_track_sampler_unit_tb.sv -----
// Testbench for the keyframe track sampler: directed and random load/sample streams.
`timescale 1ns / 100ps

module keyframe_track_sampler_unit_tb;

  localparam int unsigned NKEYS = kts_pkg::MAX_KEYS_DEF;
  localparam longint unsigned CYCLE_LIMIT = 4_000_000;

  typedef int quad_t[4];

  typedef struct packed {
    logic [31:0] sample_time;
    logic [31:0] comp_w;
    logic [31:0] comp_z;
    logic [31:0] comp_y;
    logic [31:0] comp_x;
    logic [31:0] key_time;
    logic [5:0]  key_index;
  } track_req_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [199:0] s_axis_tdata = '0;
  logic         s_axis_tuser = kts_pkg::OP_LOAD;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [7:0]   cfg_data_i = '0;

  keyframe_track_sampler_unit i_dut (.*);

  // predictor state
  logic        mode_q;
  logic [6:0]  key_count_q;
  logic [31:0] key_time_mem[NKEYS];
  quad_t       key_comp_mem[NKEYS];
  logic [127:0] expected_out[$];

  int          err_count = 0;
  int          sent_items;
  bit          no_idle;
  longint unsigned cycles = 0;

  initial forever #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout, %0d results still pending", $time, expected_out.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic int lerp_q16(int a, int b, longint f);
    longint d;
    d = longint'(b) - longint'(a);
    return sat32(longint'(a) + ((d * f) >>> 16));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= r + bitv) begin
        s -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic quad_t norm_quat(quad_t q);
    longint unsigned s, m;
    longint v;
    quad_t o;
    s = 0;
    for (int k = 0; k < 4; k++) begin
      v = q[k];
      s += longint'(v * v) >> 2;
    end
    m = int_sqrt(s);
    o = q;
    if (m != 0)
      for (int k = 0; k < 4; k++) o[k] = sat32((longint'(q[k]) * 32768) / longint'(m));
    return o;
  endfunction

  function automatic logic [127:0] interp_track(logic [31:0] t);
    int unsigned n, seg;
    longint num, den, f, dot;
    quad_t a, b, r;
    n = (key_count_q == 0) ? 1 : (key_count_q > NKEYS) ? NKEYS : key_count_q;
    if (n == 1) begin
      r = key_comp_mem[0];
      if (mode_q == kts_pkg::MODE_VECTOR) r[3] = 0;
    end else begin
      seg = 0;
      for (int unsigned i = 0; i + 1 < n; i++)
        if (t < key_time_mem[i+1]) begin
          seg = i;
          break;
        end
      den = longint'(key_time_mem[seg+1]) - longint'(key_time_mem[seg]);
      num = longint'(t) - longint'(key_time_mem[seg]);
      if (den <= 0 || num <= 0) f = 0;
      else if (num >= den) f = 65536;
      else f = (num * 65536) / den;
      a = key_comp_mem[seg];
      b = key_comp_mem[seg+1];
      if (mode_q == kts_pkg::MODE_VECTOR) begin
        for (int k = 0; k < 3; k++) r[k] = lerp_q16(a[k], b[k], f);
        r[3] = 0;
      end else begin
        a = norm_quat(a);
        b = norm_quat(b);
        dot = 0;
        for (int k = 0; k < 4; k++) dot += longint'(a[k]) * longint'(b[k]);
        if (dot < 0)
          for (int k = 0; k < 4; k++) b[k] = sat32(-longint'(b[k]));
        for (int k = 0; k < 4; k++) r[k] = lerp_q16(a[k], b[k], f);
        r = norm_quat(r);
      end
    end
    return {r[3], r[2], r[1], r[0]};
  endfunction

  task automatic send_req(logic op, track_req_t req);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {2'b00, req};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_items++;
    if (op == kts_pkg::OP_LOAD) begin
      key_time_mem[req.key_index] = req.key_time;
      key_comp_mem[req.key_index] = '{req.comp_x, req.comp_y, req.comp_z, req.comp_w};
    end else begin
      expected_out = {expected_out, interp_track(req.sample_time)};
    end
  endtask

  task automatic load_key(int idx, logic [31:0] kt, int x, int y, int z, int w);
    track_req_t req;
    req = {$urandom(), w, z, y, x, kt, 6'(idx)};
    send_req(kts_pkg::OP_LOAD, req);
  endtask

  task automatic sample_at(logic [31:0] t);
    track_req_t req;
    req = {t, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 6'($urandom())};
    send_req(kts_pkg::OP_SAMPLE, req);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_out.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == kts_pkg::REG_TRACK_MODE) mode_q = val[0];
    else if (idx == kts_pkg::REG_KEY_COUNT) key_count_q = val[6:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // m_axis stall generator
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    logic [127:0] exp_v;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_out.size() == 0) begin
        $display("%0t unexpected result %h", $time, m_axis_tdata);
        err_count++;
      end else begin
        exp_v = expected_out.pop_front();
        for (int k = 0; k < 4; k++)
          if (m_axis_tdata[32*k +: 32] != exp_v[32*k +: 32]) begin
            $display("%0t out field %0d: expected %h actual %h", $time, k,
                     exp_v[32*k +: 32], m_axis_tdata[32*k +: 32]);
            err_count++;
          end
      end
    end
  end

  task automatic test_single_key();
    load_key(0, 32'd100, 32'h7fffffff, 32'h80000000, 1, -1);
    sample_at(32'd0);
    sample_at(32'hffffffff);
    wait_idle();
    write_reg(kts_pkg::REG_TRACK_MODE, 8'(kts_pkg::MODE_QUAT));
    sample_at(32'd5);
    wait_idle();
  endtask

  task automatic test_segments();
    load_key(1, 32'h300, -32'h10000, 32'h20000, 32'h7fffffff, 32'h1234);
    write_reg(kts_pkg::REG_TRACK_MODE, 8'(kts_pkg::MODE_VECTOR));
    write_reg(kts_pkg::REG_KEY_COUNT, 8'd2);
    write_reg(2'd2, 8'hff);   // unmapped, ignored
    write_reg(2'd3, 8'h01);
    sample_at(32'd0);         // before first key
    sample_at(32'd100);
    sample_at(32'h200);
    sample_at(32'h300);
    sample_at(32'hffffffff);  // past last key
    load_key(1, 32'd100, 32'h80000000, 5, 6, 7);  // zero-length segment
    sample_at(32'd100);
    sample_at(32'd1000);
    wait_idle();
  endtask

  task automatic test_quat();
    write_reg(kts_pkg::REG_TRACK_MODE, 8'(kts_pkg::MODE_QUAT));
    load_key(0, 32'd0, 0, 0, 0, 32'h10000);
    load_key(1, 32'h1000, 0, 0, 0, -32'h10000);   // opposite hemisphere
    sample_at(32'h800);
    load_key(1, 32'h1000, 32'h8000, 0, 0, 32'h8000);
    sample_at(32'h400);
    load_key(0, 32'd0, 0, 0, 0, 0);               // zero-length quaternion
    sample_at(32'h100);
    load_key(0, 32'd0, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    sample_at(32'hc00);
    wait_idle();
  endtask

  function automatic int rand_comp(bit wide);
    return wide ? int'($urandom()) : $urandom_range(0, 32'h3ffff) - 32'h20000;
  endfunction

  task automatic load_track(int n);
    longint unsigned t;
    bit sorted, wide;
    sorted = $urandom_range(0, 99) < 85;
    wide = $urandom_range(0, 2) == 0;
    t = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 32'h10000000);
    for (int i = 0; i < n; i++) begin
      if (sorted) t += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1 << 20);
      else t = $urandom();
      load_key(i, t > 64'hffffffff ? 32'hffffffff : 32'(t), rand_comp(wide),
               rand_comp(wide), rand_comp(wide), rand_comp(wide));
    end
  endtask

  task automatic test_random();
    int n, r, lastk;
    load_track(NKEYS);  // every slot written from here on
    while (sent_items < 480) begin
      wait_idle();
      r = $urandom_range(0, 99);
      if (r < 10) n = 0;
      else if (r < 20) n = 127;
      else if (r < 25) n = NKEYS;
      else if (r < 30) n = 1;
      else n = $urandom_range(2, 8);
      no_idle = $urandom_range(0, 4) == 0;
      write_reg(kts_pkg::REG_TRACK_MODE, 8'($urandom_range(0, 1)));
      write_reg(kts_pkg::REG_KEY_COUNT, 8'(n));
      if ($urandom_range(0, 5) == 0) write_reg(2'($urandom_range(2, 3)), 8'($urandom()));
      n = (n == 0) ? 1 : (n > NKEYS) ? NKEYS : n;
      load_track(n);
      lastk = n - 1;
      repeat (15) begin
        r = $urandom_range(0, 99);
        if (r < 10) load_key($urandom_range(0, NKEYS - 1), $urandom(), rand_comp(1),
                             rand_comp(0), rand_comp(1), rand_comp(0));
        else if (r < 20) sample_at($urandom());
        else if (r < 30) sample_at(key_time_mem[$urandom_range(0, lastk)]);
        else sample_at(key_time_mem[0] +
                       $urandom_range(0, key_time_mem[lastk] - key_time_mem[0] + 32'h100));
      end
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  initial begin
    sent_items = 0;
    no_idle = 1'b0;
    mode_q = kts_pkg::MODE_VECTOR;
    key_count_q = 7'd1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_single_key();
    test_segments();
    test_quat();
    test_random();
    repeat (200) @(posedge clk_i);
    if (err_count == 0 && expected_out.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/kts_pkg.sv
rtl/kts_ram.sv
rtl/keyframe_track_sampler_unit.sv
tb/keyframe_track_sampler_unit_tb.sv
